// ===== design/bpa_pkg.sv =====
package bpa_pkg;

  localparam int MaxOrder = 10;
  localparam int MaxPages = 65536;
  localparam int NumOrd   = MaxOrder + 1;
  localparam int PageW    = 16;
  localparam int LinkW    = 17;
  localparam int OrdW     = 4;
  localparam int RefW     = 16;
  localparam int UsedW    = 17;
  localparam int IdxW     = MaxOrder + 1;

  localparam logic [LinkW-1:0] NilLink = LinkW'(MaxPages);
  localparam logic [RefW-1:0]  RefMax  = '1;

  typedef enum logic [2:0] {
    ReqAlloc   = 3'd0,
    ReqFree    = 3'd1,
    ReqInc     = 3'd2,
    ReqDec     = 3'd3,
    ReqQuery   = 3'd4,
    ReqReserve = 3'd5,
    ReqAdd     = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StNoMem     = 3'd1,
    StBadPage   = 3'd2,
    StPageFree  = 3'd3,
    StShared    = 3'd4,
    StUnderflow = 3'd5
  } status_e;

  typedef struct packed {
    logic [OrdW-1:0] order;
    logic            alloc;
    logic [RefW-1:0] refc;
  } meta_t;

  typedef struct packed {
    logic [LinkW-1:0] nxt;
    logic [LinkW-1:0] prv;
  } link_t;

  typedef struct packed {
    logic [PageW-1:0] meta_raddr;
    logic             meta_we_ord;
    logic             meta_we_alloc;
    logic             meta_we_ref;
    logic [PageW-1:0] meta_waddr;
    meta_t            meta_wdata;
    logic [PageW-1:0] link_raddr;
    logic             link_we_next;
    logic             link_we_prev;
    logic [PageW-1:0] link_waddr;
    link_t            link_wdata;
  } mem_req_t;

endpackage

// ===== design/bpa_page_mem.sv =====
module bpa_page_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::mem_req_t mem_req_i,
  output logic              busy_o,
  output bpa_pkg::meta_t    meta_rd_o,
  output bpa_pkg::link_t    link_rd_o
);

  bpa_pkg::meta_t meta_mem [bpa_pkg::MaxPages];
  bpa_pkg::link_t link_mem [bpa_pkg::MaxPages];

  logic [bpa_pkg::PageW:0] clr_q, clr_d;
  bpa_pkg::meta_t          meta_rd_q;
  bpa_pkg::link_t          link_rd_q;

  assign busy_o    = !clr_q[bpa_pkg::PageW];
  assign clr_d     = busy_o ? clr_q + 1'b1 : clr_q;
  assign meta_rd_o = meta_rd_q;
  assign link_rd_o = link_rd_q;

  // clearing sweep over the page store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_o) begin
      meta_mem[clr_q[bpa_pkg::PageW-1:0]] <= '0;
    end else begin
      if (mem_req_i.meta_we_ord) begin
        meta_mem[mem_req_i.meta_waddr].order <= mem_req_i.meta_wdata.order;
      end
      if (mem_req_i.meta_we_alloc) begin
        meta_mem[mem_req_i.meta_waddr].alloc <= mem_req_i.meta_wdata.alloc;
      end
      if (mem_req_i.meta_we_ref) begin
        meta_mem[mem_req_i.meta_waddr].refc <= mem_req_i.meta_wdata.refc;
      end
    end
    meta_rd_q <= meta_mem[mem_req_i.meta_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_req_i.link_we_next) begin
      link_mem[mem_req_i.link_waddr].nxt <= mem_req_i.link_wdata.nxt;
    end
    if (mem_req_i.link_we_prev) begin
      link_mem[mem_req_i.link_waddr].prv <= mem_req_i.link_wdata.prv;
    end
    link_rd_q <= link_mem[mem_req_i.link_raddr];
  end

endmodule

// ===== design/bpa_ctrl.sv =====
module bpa_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [bpa_pkg::LinkW-1:0]  lim_i,
  input  logic                       busy_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [bpa_pkg::PageW-1:0]  page_i,
  input  logic [bpa_pkg::LinkW-1:0]  end_page_i,
  input  logic [bpa_pkg::LinkW-1:0]  count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [bpa_pkg::PageW-1:0]  result_page_o,
  output logic [bpa_pkg::RefW-1:0]   share_count_o,
  output logic [bpa_pkg::OrdW-1:0]   block_order_o,
  output logic                       is_allocated_o,
  output logic                       is_shared_o,
  output logic [bpa_pkg::UsedW-1:0]  used_pages_o,
  output bpa_pkg::mem_req_t          mem_req_o,
  input  bpa_pkg::meta_t             meta_rd_i,
  input  bpa_pkg::link_t             link_rd_i
);

  localparam int LW = bpa_pkg::LinkW;
  localparam int PW = bpa_pkg::PageW;
  localparam int OW = bpa_pkg::OrdW;
  localparam int IW = bpa_pkg::IdxW;
  localparam int SW = 5;

  localparam logic [SW-1:0] SIdle    = 5'd0;
  localparam logic [SW-1:0] SEmitRd  = 5'd1;
  localparam logic [SW-1:0] SEmitWt  = 5'd2;
  localparam logic [SW-1:0] SAFind   = 5'd3;
  localparam logic [SW-1:0] SASplit  = 5'd4;
  localparam logic [SW-1:0] SARef    = 5'd5;
  localparam logic [SW-1:0] SFRd     = 5'd6;
  localparam logic [SW-1:0] SFChk    = 5'd7;
  localparam logic [SW-1:0] SFCRd    = 5'd8;
  localparam logic [SW-1:0] SFCCk    = 5'd9;
  localparam logic [SW-1:0] SFClr    = 5'd10;
  localparam logic [SW-1:0] SFCo     = 5'd11;
  localparam logic [SW-1:0] SFCoCk   = 5'd12;
  localparam logic [SW-1:0] SFCoUp   = 5'd13;
  localparam logic [SW-1:0] SCRd     = 5'd14;
  localparam logic [SW-1:0] SCCk     = 5'd15;
  localparam logic [SW-1:0] SRLoop   = 5'd16;
  localparam logic [SW-1:0] SRCk     = 5'd17;
  localparam logic [SW-1:0] SDLoop   = 5'd18;
  localparam logic [SW-1:0] SDCk     = 5'd19;
  localparam logic [SW-1:0] SDRun    = 5'd20;
  localparam logic [SW-1:0] SDRunCk  = 5'd21;
  localparam logic [SW-1:0] SDSet    = 5'd22;
  localparam logic [SW-1:0] SDNext   = 5'd23;
  localparam logic [SW-1:0] SUlRd    = 5'd24;
  localparam logic [SW-1:0] SUlA     = 5'd25;
  localparam logic [SW-1:0] SUlB     = 5'd26;
  localparam logic [SW-1:0] SPuA     = 5'd27;
  localparam logic [SW-1:0] SPuB     = 5'd28;

  logic [SW-1:0]     state_q, state_d, ret_q, ret_d;
  bpa_pkg::req_e     kind_q, kind_d;
  logic [PW-1:0]     page_q, page_d, rp_q, rp_d;
  logic [LW-1:0]     end_q, end_d, cur_q, cur_d, aux_q, aux_d, nx_q, nx_d, pv_q, pv_d;
  logic [OW-1:0]     ord_q, ord_d, want_q, want_d;
  logic [IW-1:0]     idx_q, idx_d, cap_q, cap_d;
  bpa_pkg::status_e  st_q, st_d;
  logic              fail_q, fail_d;
  logic [LW-1:0]     used_q, used_d;
  logic [LW-1:0]     heads_q [bpa_pkg::NumOrd];
  logic [LW-1:0]     heads_d [bpa_pkg::NumOrd];

  logic              out_valid_q, out_valid_d;
  bpa_pkg::status_e  out_st_q, out_st_d;
  logic [PW-1:0]     out_page_q, out_page_d;
  logic [bpa_pkg::RefW-1:0] out_ref_q, out_ref_d;
  logic [OW-1:0]     out_ord_q, out_ord_d;
  logic              out_alloc_q, out_alloc_d;
  logic              out_shared_q, out_shared_d;
  logic [LW-1:0]     out_used_q, out_used_d;

  logic              accept, pin, show, last_w, last_o;
  logic [LW-1:0]     a_addr, split_bud, co_bud, run_addr, lowbit, cap_c, merge_page;
  logic [OW-1:0]     split_ord, want_c, find_ord, flog, clamp_ord;
  logic              find_ok;
  logic [IW-1:0]     size_w, size_o;
  logic [LW:0]       sum_w, sum_1;
  logic [LW-1:0]     used_plus_w, used_plus_1, used_minus_o;

  assign in_stall_o = busy_i || (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign pin        = {1'b0, page_i} < lim_i;
  assign show       = !fail_q && ({1'b0, rp_q} < lim_i);

  assign a_addr     = cur_q + LW'(idx_q);
  assign run_addr   = a_addr;
  assign split_ord  = ord_q - 1'b1;
  assign split_bud  = cur_q + (LW'(1) << split_ord);
  assign co_bud     = cur_q ^ (LW'(1) << ord_q);
  assign merge_page = (aux_q < cur_q) ? aux_q : cur_q;
  assign size_w     = IW'(1) << want_q;
  assign size_o     = IW'(1) << ord_q;
  assign last_w     = idx_q == size_w - 1'b1;
  assign last_o     = idx_q == size_o - 1'b1;
  assign clamp_ord  = (meta_rd_i.order > OW'(bpa_pkg::MaxOrder)) ?
                      OW'(bpa_pkg::MaxOrder) : meta_rd_i.order;

  assign sum_w        = {1'b0, used_q} + (LW + 1)'(size_w);
  assign sum_1        = {1'b0, used_q} + 1'b1;
  assign used_plus_w  = sum_w[LW] ? '1 : sum_w[LW-1:0];
  assign used_plus_1  = sum_1[LW] ? '1 : sum_1[LW-1:0];
  assign used_minus_o = (LW'(size_o) > used_q) ? '0 : used_q - LW'(size_o);

  // rounded-up order of the page count
  always_comb begin
    want_c = OW'(bpa_pkg::MaxOrder);
    for (int w = bpa_pkg::MaxOrder - 1; w >= 0; w--) begin
      if (count_i <= (LW'(1) << w)) want_c = OW'(w);
    end
  end

  // smallest non-empty list at or above the wanted order
  always_comb begin
    find_ord = '0;
    find_ok  = 1'b0;
    for (int w = bpa_pkg::MaxOrder; w >= 0; w--) begin
      if ((OW'(w) >= want_q) && !heads_q[w][LW-1]) begin
        find_ord = OW'(w);
        find_ok  = 1'b1;
      end
    end
  end

  // largest block order fitting the free run
  always_comb begin
    flog = '0;
    for (int w = 1; w <= bpa_pkg::MaxOrder; w++) begin
      if (idx_q >= (IW'(1) << w)) flog = OW'(w);
    end
  end

  always_comb begin
    lowbit = cur_q & (~cur_q + 1'b1);
    cap_c  = LW'(1) << bpa_pkg::MaxOrder;
    if ((cur_q != '0) && (lowbit < cap_c)) cap_c = lowbit;
    if ((end_q - cur_q) < cap_c) cap_c = end_q - cur_q;
    if ((lim_i - cur_q) < cap_c) cap_c = lim_i - cur_q;
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    kind_d   = kind_q;
    page_d   = page_q;
    rp_d     = rp_q;
    end_d    = end_q;
    cur_d    = cur_q;
    aux_d    = aux_q;
    nx_d     = nx_q;
    pv_d     = pv_q;
    ord_d    = ord_q;
    want_d   = want_q;
    idx_d    = idx_q;
    cap_d    = cap_q;
    st_d     = st_q;
    fail_d   = fail_q;
    used_d   = used_q;
    heads_d  = heads_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_st_d     = out_st_q;
    out_page_d   = out_page_q;
    out_ref_d    = out_ref_q;
    out_ord_d    = out_ord_q;
    out_alloc_d  = out_alloc_q;
    out_shared_d = out_shared_q;
    out_used_d   = out_used_q;
    mem_req_o    = '0;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          kind_d = bpa_pkg::req_e'(req_type_i);
          page_d = page_i;
          rp_d   = page_i;
          end_d  = end_page_i;
          cur_d  = {1'b0, page_i};
          fail_d = 1'b0;
          st_d   = bpa_pkg::StOk;
          idx_d  = '0;
          unique case (bpa_pkg::req_e'(req_type_i))
            bpa_pkg::ReqAlloc: begin
              if (count_i == '0) begin
                st_d    = bpa_pkg::StNoMem;
                fail_d  = 1'b1;
                rp_d    = '0;
                state_d = SEmitRd;
              end else begin
                want_d  = want_c;
                state_d = SAFind;
              end
            end
            bpa_pkg::ReqFree: begin
              if (!pin) begin
                st_d    = bpa_pkg::StBadPage;
                state_d = SEmitRd;
              end else begin
                state_d = SFRd;
              end
            end
            bpa_pkg::ReqInc, bpa_pkg::ReqDec: begin
              if (!pin) begin
                st_d    = bpa_pkg::StBadPage;
                state_d = SEmitRd;
              end else begin
                state_d = SCRd;
              end
            end
            bpa_pkg::ReqQuery: begin
              st_d    = pin ? bpa_pkg::StOk : bpa_pkg::StBadPage;
              state_d = SEmitRd;
            end
            bpa_pkg::ReqReserve: state_d = SRLoop;
            bpa_pkg::ReqAdd:     state_d = SDLoop;
            default:             state_d = SEmitRd;
          endcase
        end
      end

      SEmitRd: begin
        mem_req_o.meta_raddr = rp_q;
        state_d = SEmitWt;
      end

      SEmitWt: begin
        mem_req_o.meta_raddr = rp_q;
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_st_d     = st_q;
          out_page_d   = rp_q;
          out_ref_d    = show ? meta_rd_i.refc : '0;
          out_ord_d    = show ? meta_rd_i.order : '0;
          out_alloc_d  = show && meta_rd_i.alloc;
          out_shared_d = show && (meta_rd_i.refc >= 2);
          out_used_d   = used_q;
          state_d      = SIdle;
        end
      end

      SAFind: begin
        if (!find_ok) begin
          st_d    = bpa_pkg::StNoMem;
          fail_d  = 1'b1;
          rp_d    = '0;
          state_d = SEmitRd;
        end else begin
          ord_d   = find_ord;
          cur_d   = heads_q[find_ord];
          aux_d   = heads_q[find_ord];
          ret_d   = SASplit;
          state_d = SUlRd;
        end
      end

      SASplit: begin
        if (ord_q > want_q) begin
          ord_d = split_ord;
          if (!split_bud[LW-1]) begin
            aux_d = split_bud;
            mem_req_o.meta_waddr       = split_bud[PW-1:0];
            mem_req_o.meta_we_ord      = 1'b1;
            mem_req_o.meta_we_alloc    = 1'b1;
            mem_req_o.meta_wdata.order = split_ord;
            mem_req_o.meta_wdata.alloc = 1'b0;
            ret_d   = SASplit;
            state_d = SPuA;
          end
        end else begin
          idx_d   = '0;
          state_d = SARef;
        end
      end

      SARef: begin
        mem_req_o.meta_waddr       = a_addr[PW-1:0];
        mem_req_o.meta_we_ref      = a_addr < lim_i;
        mem_req_o.meta_we_ord      = idx_q == '0;
        mem_req_o.meta_we_alloc    = idx_q == '0;
        mem_req_o.meta_wdata.order = want_q;
        mem_req_o.meta_wdata.alloc = 1'b1;
        mem_req_o.meta_wdata.refc  = bpa_pkg::RefW'(1);
        if (last_w) begin
          used_d  = used_plus_w;
          rp_d    = cur_q[PW-1:0];
          st_d    = bpa_pkg::StOk;
          state_d = SEmitRd;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      SFRd: begin
        mem_req_o.meta_raddr = page_q;
        state_d = SFChk;
      end

      SFChk: begin
        if (!meta_rd_i.alloc) begin
          st_d    = bpa_pkg::StPageFree;
          state_d = SEmitRd;
        end else begin
          ord_d   = clamp_ord;
          idx_d   = '0;
          state_d = SFCRd;
        end
      end

      SFCRd: begin
        mem_req_o.meta_raddr = a_addr[PW-1:0];
        state_d = SFCCk;
      end

      SFCCk: begin
        if ((a_addr < lim_i) && (meta_rd_i.refc > 1)) begin
          st_d    = bpa_pkg::StShared;
          state_d = SEmitRd;
        end else if (last_o) begin
          idx_d   = '0;
          state_d = SFClr;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = SFCRd;
        end
      end

      SFClr: begin
        mem_req_o.meta_waddr       = a_addr[PW-1:0];
        mem_req_o.meta_we_ref      = a_addr < lim_i;
        mem_req_o.meta_we_alloc    = idx_q == '0;
        mem_req_o.meta_wdata.alloc = 1'b0;
        mem_req_o.meta_wdata.refc  = '0;
        if (last_o) begin
          used_d  = used_minus_o;
          state_d = SFCo;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      SFCo: begin
        if ((ord_q < OW'(bpa_pkg::MaxOrder)) && (co_bud < lim_i)) begin
          mem_req_o.meta_raddr = co_bud[PW-1:0];
          aux_d   = co_bud;
          state_d = SFCoCk;
        end else begin
          aux_d   = cur_q;
          ret_d   = SEmitRd;
          state_d = SPuA;
        end
      end

      SFCoCk: begin
        if (meta_rd_i.alloc || (meta_rd_i.order != ord_q)) begin
          aux_d   = cur_q;
          ret_d   = SEmitRd;
          state_d = SPuA;
        end else begin
          ret_d   = SFCoUp;
          state_d = SUlRd;
        end
      end

      SFCoUp: begin
        cur_d = merge_page;
        ord_d = ord_q + 1'b1;
        mem_req_o.meta_waddr       = merge_page[PW-1:0];
        mem_req_o.meta_we_ord      = 1'b1;
        mem_req_o.meta_wdata.order = ord_q + 1'b1;
        state_d = SFCo;
      end

      SCRd: begin
        mem_req_o.meta_raddr = page_q;
        state_d = SCCk;
      end

      SCCk: begin
        mem_req_o.meta_waddr = page_q;
        if (!meta_rd_i.alloc) begin
          st_d = bpa_pkg::StPageFree;
        end else if (meta_rd_i.refc == bpa_pkg::RefMax) begin
          st_d = bpa_pkg::StOk;
        end else if (kind_q == bpa_pkg::ReqInc) begin
          mem_req_o.meta_we_ref     = 1'b1;
          mem_req_o.meta_wdata.refc = meta_rd_i.refc + 1'b1;
        end else if (meta_rd_i.refc == '0) begin
          st_d = bpa_pkg::StUnderflow;
        end else begin
          mem_req_o.meta_we_ref     = 1'b1;
          mem_req_o.meta_wdata.refc = meta_rd_i.refc - 1'b1;
        end
        state_d = SEmitRd;
      end

      SRLoop: begin
        if ((cur_q < end_q) && (cur_q < lim_i)) begin
          mem_req_o.meta_raddr = cur_q[PW-1:0];
          state_d = SRCk;
        end else begin
          state_d = SEmitRd;
        end
      end

      SRCk: begin
        if (!meta_rd_i.alloc) begin
          mem_req_o.meta_waddr       = cur_q[PW-1:0];
          mem_req_o.meta_we_alloc    = 1'b1;
          mem_req_o.meta_wdata.alloc = 1'b1;
          used_d = used_plus_1;
        end
        cur_d   = cur_q + 1'b1;
        state_d = SRLoop;
      end

      SDLoop: begin
        if ((cur_q < end_q) && (cur_q < lim_i)) begin
          mem_req_o.meta_raddr = cur_q[PW-1:0];
          state_d = SDCk;
        end else begin
          state_d = SEmitRd;
        end
      end

      SDCk: begin
        if (meta_rd_i.alloc) begin
          cur_d   = cur_q + 1'b1;
          state_d = SDLoop;
        end else begin
          cap_d   = cap_c[IW-1:0];
          idx_d   = IW'(1);
          state_d = SDRun;
        end
      end

      SDRun: begin
        if (idx_q < cap_q) begin
          mem_req_o.meta_raddr = run_addr[PW-1:0];
          state_d = SDRunCk;
        end else begin
          state_d = SDSet;
        end
      end

      SDRunCk: begin
        if (!meta_rd_i.alloc) begin
          idx_d   = idx_q + 1'b1;
          state_d = SDRun;
        end else begin
          state_d = SDSet;
        end
      end

      SDSet: begin
        ord_d = flog;
        mem_req_o.meta_waddr       = cur_q[PW-1:0];
        mem_req_o.meta_we_ord      = 1'b1;
        mem_req_o.meta_we_alloc    = 1'b1;
        mem_req_o.meta_wdata.order = flog;
        mem_req_o.meta_wdata.alloc = 1'b0;
        aux_d   = cur_q;
        ret_d   = SDNext;
        state_d = SPuA;
      end

      SDNext: begin
        cur_d   = cur_q + (LW'(1) << ord_q);
        state_d = SDLoop;
      end

      SUlRd: begin
        mem_req_o.link_raddr = aux_q[PW-1:0];
        state_d = SUlA;
      end

      SUlA: begin
        nx_d = link_rd_i.nxt;
        pv_d = link_rd_i.prv;
        if (!link_rd_i.prv[LW-1]) begin
          mem_req_o.link_waddr     = link_rd_i.prv[PW-1:0];
          mem_req_o.link_we_next   = 1'b1;
          mem_req_o.link_wdata.nxt = link_rd_i.nxt;
        end else begin
          heads_d[ord_q] = link_rd_i.nxt;
        end
        state_d = SUlB;
      end

      SUlB: begin
        if (!nx_q[LW-1]) begin
          mem_req_o.link_waddr     = nx_q[PW-1:0];
          mem_req_o.link_we_prev   = 1'b1;
          mem_req_o.link_wdata.prv = pv_q;
        end
        state_d = ret_q;
      end

      SPuA: begin
        nx_d = heads_q[ord_q];
        mem_req_o.link_waddr     = aux_q[PW-1:0];
        mem_req_o.link_we_next   = 1'b1;
        mem_req_o.link_we_prev   = 1'b1;
        mem_req_o.link_wdata.nxt = heads_q[ord_q];
        mem_req_o.link_wdata.prv = bpa_pkg::NilLink;
        heads_d[ord_q] = aux_q;
        state_d = SPuB;
      end

      SPuB: begin
        if (!nx_q[LW-1]) begin
          mem_req_o.link_waddr     = nx_q[PW-1:0];
          mem_req_o.link_we_prev   = 1'b1;
          mem_req_o.link_wdata.prv = aux_q;
        end
        state_d = ret_q;
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < bpa_pkg::NumOrd; i++) begin
        heads_q[i] <= bpa_pkg::NilLink;
      end
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      heads_q     <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q        <= ret_d;
    kind_q       <= kind_d;
    page_q       <= page_d;
    rp_q         <= rp_d;
    end_q        <= end_d;
    cur_q        <= cur_d;
    aux_q        <= aux_d;
    nx_q         <= nx_d;
    pv_q         <= pv_d;
    ord_q        <= ord_d;
    want_q       <= want_d;
    idx_q        <= idx_d;
    cap_q        <= cap_d;
    st_q         <= st_d;
    fail_q       <= fail_d;
    out_st_q     <= out_st_d;
    out_page_q   <= out_page_d;
    out_ref_q    <= out_ref_d;
    out_ord_q    <= out_ord_d;
    out_alloc_q  <= out_alloc_d;
    out_shared_q <= out_shared_d;
    out_used_q   <= out_used_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign result_page_o  = out_page_q;
  assign share_count_o  = out_ref_q;
  assign block_order_o  = out_ord_q;
  assign is_allocated_o = out_alloc_q;
  assign is_shared_o    = out_shared_q;
  assign used_pages_o   = out_used_q;

endmodule

// ===== design/buddy_page_allocator_refcount.sv =====
// Buddy page allocator with per-page share counts. Requests are taken one at
// a time and each gives one result; a result may wait in the output register
// while the next request is taken. Query, unknown requests and early errors
// only read the page shown in the result; share-count requests read and then
// write one page; alloc finds a free list, unlinks its head block, splits it
// level by level and writes each page of the block, or fails for lack of
// memory; free checks and then clears each page of the block and coalesces
// one buddy per step; reserve checks each page in range; add range skips
// allocated pages and pushes the free runs it finds as blocks. The page store
// gives registered reads and takes one write per cycle, and every step goes
// through it. After reset the page store is cleared in a sweep over all
// 65536 pages during which requests are stalled; total_pages writes are
// taken at any time and must only be made while no request is in flight.
module buddy_page_allocator_refcount (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [bpa_pkg::LinkW-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [2:0]                 req_type_i,
  input  logic [bpa_pkg::PageW-1:0]  page_i,
  input  logic [bpa_pkg::LinkW-1:0]  end_page_i,
  input  logic [bpa_pkg::LinkW-1:0]  count_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [bpa_pkg::PageW-1:0]  result_page_o,
  output logic [bpa_pkg::RefW-1:0]   share_count_o,
  output logic [bpa_pkg::OrdW-1:0]   block_order_o,
  output logic                       is_allocated_o,
  output logic                       is_shared_o,
  output logic [bpa_pkg::UsedW-1:0]  used_pages_o
);

  logic [bpa_pkg::LinkW-1:0] total_pages_q, lim;
  logic                      busy;
  bpa_pkg::mem_req_t         mem_req;
  bpa_pkg::meta_t            meta_rd;
  bpa_pkg::link_t            link_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_pages_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      total_pages_q <= cfg_data_i;
    end
  end

  assign lim = (total_pages_q > bpa_pkg::LinkW'(bpa_pkg::MaxPages)) ?
               bpa_pkg::LinkW'(bpa_pkg::MaxPages) : total_pages_q;

  bpa_page_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .busy_o    (busy),
    .meta_rd_o (meta_rd),
    .link_rd_o (link_rd)
  );

  bpa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lim_i          (lim),
    .busy_i         (busy),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .page_i         (page_i),
    .end_page_i     (end_page_i),
    .count_i        (count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .result_page_o  (result_page_o),
    .share_count_o  (share_count_o),
    .block_order_o  (block_order_o),
    .is_allocated_o (is_allocated_o),
    .is_shared_o    (is_shared_o),
    .used_pages_o   (used_pages_o),
    .mem_req_o      (mem_req),
    .meta_rd_i      (meta_rd),
    .link_rd_i      (link_rd)
  );

endmodule

// ===== design/bpa_checker.sv =====
module bpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o,
  input logic [bpa_pkg::LinkW-1:0]  cfg_data_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [2:0]                 req_type_i,
  input logic [bpa_pkg::PageW-1:0]  page_i,
  input logic [bpa_pkg::LinkW-1:0]  end_page_i,
  input logic [bpa_pkg::LinkW-1:0]  count_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [2:0]                 status_o,
  input logic [bpa_pkg::PageW-1:0]  result_page_o,
  input logic [bpa_pkg::RefW-1:0]   share_count_o,
  input logic [bpa_pkg::OrdW-1:0]   block_order_o,
  input logic                       is_allocated_o,
  input logic                       is_shared_o,
  input logic [bpa_pkg::UsedW-1:0]  used_pages_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(result_page_o) && $stable(share_count_o) && $stable(used_pages_o))
    else $error("stalled result changed");

  a_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> is_shared_o == (share_count_o >= 16'd2))
    else $error("shared flag disagrees with share count");

  a_nomem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bpa_pkg::StNoMem) |->
    (result_page_o == '0) && (share_count_o == '0) && !is_allocated_o &&
    (block_order_o == '0))
    else $error("failed alloc shows page fields");

  a_badpage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bpa_pkg::StBadPage) |->
    (share_count_o == '0) && (block_order_o == '0) && !is_allocated_o)
    else $error("out of range page shows page fields");

endmodule

bind buddy_page_allocator_refcount bpa_checker u_bpa_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int unsigned NilPg    = MaxPages;
  localparam int unsigned UsedSat  = 32'h1FFFF;
  localparam int          WdLimit  = 2000000;
  localparam int          HoldLen  = 400;

  typedef struct {
    req_e             kind;
    logic [PageW-1:0] page;
    logic [LinkW-1:0] endp;
    logic [LinkW-1:0] cnt;
  } request_t;

  typedef struct {
    status_e          st;
    logic [PageW-1:0] pg;
    logic [RefW-1:0]  sc;
    logic [OrdW-1:0]  ord;
    logic             al;
    logic             sh;
    logic [UsedW-1:0] used;
  } outcome_t;

  typedef struct {
    req_e        kind;
    int unsigned page;
    int unsigned endp;
    int unsigned cnt;
    bit          chk;
    status_e     st;
  } row_t;

  typedef struct {
    int unsigned tot;
    int          items;
  } phase_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LinkW-1:0]    cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [2:0]          req_type_i = '0;
  logic [PageW-1:0]    page_i = '0;
  logic [LinkW-1:0]    end_page_i = '0;
  logic [LinkW-1:0]    count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [PageW-1:0]    result_page_o;
  logic [RefW-1:0]     share_count_o;
  logic [OrdW-1:0]     block_order_o;
  logic                is_allocated_o;
  logic                is_shared_o;
  logic [UsedW-1:0]    used_pages_o;

  buddy_page_allocator_refcount i_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .page_i, .end_page_i, .count_i,
    .out_valid_o, .out_stall_i, .status_o, .result_page_o, .share_count_o,
    .block_order_o, .is_allocated_o, .is_shared_o, .used_pages_o
  );

  always #2 clk_i = ~clk_i;

  // allocator state as predicted
  int unsigned tot_pages;
  int unsigned free_head [NumOrd];
  int unsigned nxt_pg [MaxPages];
  int unsigned prv_pg [MaxPages];
  logic [OrdW-1:0] ord_pg [MaxPages];
  bit          alloc_pg [MaxPages];
  logic [RefW-1:0] share_pg [MaxPages];
  bit          linked_pg [MaxPages];
  int unsigned used_cnt;

  outcome_t    pending_q [$];
  int unsigned block_heads [$];
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          n_fail = 0;
  int          n_req = 0;
  int          n_res = 0;
  int          n_cfg = 0;
  int          idle_cycles = 0;

  function automatic int unsigned page_lim();
    return tot_pages < MaxPages ? tot_pages : MaxPages;
  endfunction

  function automatic void used_add(int unsigned n);
    used_cnt = (used_cnt + n > UsedSat) ? UsedSat : used_cnt + n;
  endfunction

  function automatic void list_push(int unsigned p, int unsigned o);
    int unsigned h;
    h = free_head[o];
    nxt_pg[p] = h;
    prv_pg[p] = NilPg;
    linked_pg[p] = 1'b1;
    if (h < MaxPages) prv_pg[h] = p;
    free_head[o] = p;
  endfunction

  function automatic void list_unlink(int unsigned p, int unsigned o);
    int unsigned nx, pv;
    nx = nxt_pg[p];
    pv = prv_pg[p];
    if (pv < MaxPages) nxt_pg[pv] = nx;
    else free_head[o] = nx;
    if (nx < MaxPages) prv_pg[nx] = pv;
  endfunction

  function automatic outcome_t page_view(status_e st, int unsigned rp);
    outcome_t r;
    r = '{st: st, pg: rp[15:0], sc: '0, ord: '0, al: 1'b0, sh: 1'b0, used: used_cnt[16:0]};
    if (rp < page_lim()) begin
      r.sc = share_pg[rp];
      r.ord = ord_pg[rp];
      r.al = alloc_pg[rp];
      r.sh = share_pg[rp] >= 2;
    end
    return r;
  endfunction

  function automatic outcome_t alloc_block(int unsigned cnt);
    int unsigned want, o, hd, sz, bud;
    outcome_t r;
    r = '{st: StNoMem, pg: '0, sc: '0, ord: '0, al: 1'b0, sh: 1'b0, used: used_cnt[16:0]};
    if (cnt == 0) return r;
    want = 0;
    while (want < MaxOrder && (1 << want) < cnt) want++;
    o = want;
    while (o <= MaxOrder && free_head[o] >= MaxPages) o++;
    if (o > MaxOrder) return r;
    hd = free_head[o];
    list_unlink(hd, o);
    while (o > want) begin
      o--;
      bud = hd + (1 << o);
      if (bud < MaxPages) begin
        list_push(bud, o);
        ord_pg[bud] = o;
        alloc_pg[bud] = 1'b0;
      end
    end
    ord_pg[hd] = want;
    alloc_pg[hd] = 1'b1;
    sz = 1 << want;
    for (int unsigned i = 0; i < sz; i++)
      if (hd + i < page_lim()) share_pg[hd + i] = 1;
    used_add(sz);
    block_heads.push_back(hd);
    return page_view(StOk, hd);
  endfunction

  function automatic status_e free_block(int unsigned p);
    int unsigned o, sz, bud;
    if (p >= page_lim()) return StBadPage;
    if (!alloc_pg[p]) return StPageFree;
    o = ord_pg[p] > MaxOrder ? MaxOrder : ord_pg[p];
    sz = 1 << o;
    for (int unsigned i = 0; i < sz; i++)
      if (p + i < page_lim() && share_pg[p + i] > 1) return StShared;
    alloc_pg[p] = 1'b0;
    for (int unsigned i = 0; i < sz; i++)
      if (p + i < page_lim()) share_pg[p + i] = 0;
    used_cnt = sz > used_cnt ? 0 : used_cnt - sz;
    while (o < MaxOrder) begin
      bud = p ^ (1 << o);
      if (bud >= page_lim()) break;
      if (alloc_pg[bud] || ord_pg[bud] != o) break;
      list_unlink(bud, o);
      if (bud < p) p = bud;
      o++;
      ord_pg[p] = o;
    end
    list_push(p, o);
    return StOk;
  endfunction

  // a free may only coalesce with buddies whose links were written
  function automatic bit free_is_clean(int unsigned p);
    int unsigned o, sz, bud;
    if (p >= page_lim() || !alloc_pg[p]) return 1'b1;
    o = ord_pg[p] > MaxOrder ? MaxOrder : ord_pg[p];
    sz = 1 << o;
    for (int unsigned i = 0; i < sz; i++)
      if (p + i < page_lim() && share_pg[p + i] > 1) return 1'b1;
    while (o < MaxOrder) begin
      bud = p ^ (1 << o);
      if (bud >= page_lim()) break;
      if (alloc_pg[bud] || ord_pg[bud] != o) break;
      if (!linked_pg[bud]) return 1'b0;
      if (bud < p) p = bud;
      o++;
    end
    return 1'b1;
  endfunction

  function automatic void add_range(int unsigned first, int unsigned last);
    int unsigned cur, cap, run, o, lsb;
    cur = first;
    while (cur < last && cur < page_lim()) begin
      if (alloc_pg[cur]) begin
        cur++;
        continue;
      end
      cap = 1 << MaxOrder;
      lsb = cur & (~cur + 1);
      if (cur != 0 && lsb < cap) cap = lsb;
      if (last - cur < cap) cap = last - cur;
      if (page_lim() - cur < cap) cap = page_lim() - cur;
      run = 1;
      while (run < cap && !alloc_pg[cur + run]) run++;
      o = 0;
      while (o < MaxOrder && (2 << o) <= run) o++;
      ord_pg[cur] = o;
      alloc_pg[cur] = 1'b0;
      list_push(cur, o);
      cur += 1 << o;
    end
  endfunction

  function automatic outcome_t predict_request(request_t rq);
    int unsigned p;
    status_e st;
    p = rq.page;
    st = StOk;
    case (rq.kind)
      ReqAlloc: return alloc_block(rq.cnt);
      ReqFree: st = free_block(p);
      ReqInc, ReqDec: begin
        if (p >= page_lim()) st = StBadPage;
        else if (!alloc_pg[p]) st = StPageFree;
        else if (share_pg[p] == RefMax) st = StOk;
        else if (rq.kind == ReqInc) share_pg[p]++;
        else if (share_pg[p] == 0) st = StUnderflow;
        else share_pg[p]--;
      end
      ReqQuery: st = p >= page_lim() ? StBadPage : StOk;
      ReqReserve: begin
        for (int unsigned q = p; q < rq.endp && q < page_lim(); q++)
          if (!alloc_pg[q]) begin
            alloc_pg[q] = 1'b1;
            used_add(1);
          end
      end
      ReqAdd: add_range(p, rq.endp);
      default: ;
    endcase
    return page_view(st, p);
  endfunction

  task automatic issue(request_t rq, bit chk, status_e st);
    outcome_t r;
    in_valid_i <= 1'b1;
    req_type_i <= rq.kind;
    page_i <= rq.page;
    end_page_i <= rq.endp;
    count_i <= rq.cnt;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_request(rq);
    if (chk) r.st = st;
    pending_q.push_back(r);
    n_req++;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic park();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_total(int unsigned v);
    park();
    wait (pending_q.size() == 0);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v[16:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tot_pages = v;
    n_cfg++;
  endtask

  function automatic int unsigned pick_page();
    if (block_heads.size() > 0 && $urandom_range(0, 3) != 0)
      return block_heads[$urandom_range(0, block_heads.size() - 1)];
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, page_lim() + 2);
  endfunction

  function automatic request_t random_request();
    request_t rq;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    rq = '{kind: ReqQuery, page: '0, endp: '0, cnt: '0};
    rq.endp = $urandom_range(0, 131071);
    rq.cnt = $urandom_range(0, 131071);
    if (sel < 30) begin
      rq.kind = ReqAlloc;
      case ($urandom_range(0, 19))
        0: rq.cnt = 0;
        1: rq.cnt = $urandom_range(1, 1100);
        2: rq.cnt = $urandom_range(0, 1) ? 65536 : 131071;
        default: rq.cnt = $urandom_range(1, 8);
      endcase
    end else if (sel < 55) begin
      rq.kind = ReqFree;
      rq.page = pick_page();
      if (!free_is_clean(rq.page)) rq.kind = ReqQuery;
    end else if (sel < 75) begin
      rq.kind = $urandom_range(0, 2) != 0 ? ReqInc : ReqDec;
      rq.page = pick_page();
    end else if (sel < 85) begin
      rq.page = $urandom_range(0, 1) ? $urandom_range(0, 65535) : pick_page();
    end else begin
      rq.kind = sel < 93 ? ReqReserve : ReqAdd;
      if ($urandom_range(0, 5) == 0) begin
        rq.page = $urandom_range(65500, 65535);
      end else begin
        rq.page = $urandom_range(0, page_lim() + 4);
        rq.endp = rq.page + $urandom_range(0, 9) - 1;
      end
    end
    return rq;
  endfunction

  // receiver side
  always @(posedge clk_i) begin
    if (hold_req) begin
      out_stall_i <= 1'b1;
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= HoldLen) begin
        hold_req <= 1'b0;
        idle_cycles = 0;
      end
    end else begin
      out_stall_i <= !quiet && $urandom_range(0, 99) < 10;
    end
  end

  always @(posedge clk_i) begin
    outcome_t e;
    if (out_valid_o && !out_stall_i) begin
      n_res++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with none expected, got page %h", $realtime, result_page_o);
        n_fail++;
      end else begin
        e = pending_q.pop_front();
        if ({status_o, result_page_o, share_count_o, block_order_o, is_allocated_o,
             is_shared_o, used_pages_o} !==
            {e.st, e.pg, e.sc, e.ord, e.al, e.sh, e.used}) begin
          $display("%0t: mismatch expected st=%0d pg=%h sc=%h ord=%0d al=%b sh=%b used=%h",
                   $realtime, e.st, e.pg, e.sc, e.ord, e.al, e.sh, e.used);
          $display("%0t:          actual st=%0d pg=%h sc=%h ord=%0d al=%b sh=%b used=%h",
                   $realtime, status_o, result_page_o, share_count_o, block_order_o,
                   is_allocated_o, is_shared_o, used_pages_o);
          n_fail++;
        end
      end
    end
  end

  // watchdog on cycles without progress
  initial begin
    int quiet_cnt;
    quiet_cnt = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o) || (!in_valid_i && pending_q.size() == 0))
        quiet_cnt = 0;
      else
        quiet_cnt++;
      if (quiet_cnt >= WdLimit) begin
        $display("%0t: timeout, %0d results outstanding", $realtime, pending_q.size());
        $display("** buddy_page_allocator_refcount: FAILED **");
        $finish;
      end
    end
  end

  row_t directed [] = '{
    '{ReqQuery, 0, 0, 0, 1, StOk},
    '{ReqQuery, 64, 0, 0, 1, StBadPage},
    '{ReqQuery, 65535, 0, 0, 1, StBadPage},
    '{ReqAlloc, 0, 0, 0, 1, StNoMem},
    '{ReqAlloc, 0, 0, 1, 1, StNoMem},
    '{ReqFree, 5, 0, 0, 1, StPageFree},
    '{ReqInc, 5, 0, 0, 1, StPageFree},
    '{ReqDec, 70, 0, 0, 1, StBadPage},
    '{ReqFree, 100, 0, 0, 1, StBadPage},
    '{ReqAdd, 0, 64, 0, 1, StOk},
    '{ReqAlloc, 0, 0, 3, 0, StOk},
    '{ReqAlloc, 0, 0, 1, 0, StOk},
    '{ReqInc, 0, 0, 0, 1, StOk},
    '{ReqFree, 0, 0, 0, 1, StShared},
    '{ReqDec, 0, 0, 0, 1, StOk},
    '{ReqDec, 0, 0, 0, 1, StOk},
    '{ReqDec, 0, 0, 0, 1, StUnderflow},
    '{ReqFree, 0, 0, 0, 1, StOk},
    '{ReqReserve, 10, 12, 0, 1, StOk},
    '{ReqAdd, 10, 12, 0, 1, StOk},
    '{ReqFree, 10, 0, 0, 1, StOk},
    '{ReqReserve, 20, 3, 0, 1, StOk},
    '{ReqAlloc, 0, 0, 65536, 1, StNoMem},
    '{ReqAlloc, 0, 0, 131071, 1, StNoMem}
  };

  phase_t phases [] = '{
    '{16, 60}, '{1024, 100}, '{1, 30}, '{0, 20}, '{256, 80}, '{65536, 80}, '{131071, 80}
  };

  initial begin
    request_t rq;
    int unsigned mark, top;
    for (int o = 0; o < NumOrd; o++) free_head[o] = NilPg;
    tot_pages = 0;
    used_cnt = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_total(64);
    foreach (directed[i]) begin
      rq = '{kind: directed[i].kind, page: directed[i].page, endp: directed[i].endp,
             cnt: directed[i].cnt};
      issue(rq, directed[i].chk, directed[i].st);
    end

    mark = 64;
    foreach (phases[ph]) begin
      write_total(phases[ph].tot);
      top = page_lim() < 2048 ? page_lim() : 2048;
      if (top > mark) begin
        rq = '{kind: ReqAdd, page: mark, endp: top, cnt: '0};
        issue(rq, 1'b0, StOk);
        mark = top;
      end
      quiet = phases[ph].tot == 256;
      for (int i = 0; i < phases[ph].items; i++) begin
        if (phases[ph].tot == 1024 && i == 10) hold_req = 1'b1;
        issue(random_request(), 1'b0, StOk);
      end
      quiet = 1'b0;
    end

    park();
    wait (pending_q.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("covered %0d requests, %0d results, %0d page-count settings incl. 0 and max",
             n_req, n_res, n_cfg);
    $display("long output hold-off applied once; one phase ran with no idling");
    if (n_fail == 0 && pending_q.size() == 0) begin
      $display("** buddy_page_allocator_refcount: PASSED **");
    end else begin
      $display("** buddy_page_allocator_refcount: FAILED **");
    end
    $finish;
  end

endmodule
